@@ rtl/core/ibed_pkg.sv @@
// Shared types and constants for the impact and brake event detector.
// Used by every module under rtl/core; depends on nothing else.
package ibed_pkg;

    // Field widths
    localparam int AXIS_W  = 16;
    localparam int TIME_W  = 32;
    localparam int SUMSQ_W = 32;
    localparam int MAG_W   = 16;
    localparam int JERK_W  = 22;
    localparam int CONF_W  = 8;
    localparam int KIND_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 22;

    // Request types
    localparam logic REQ_SAMPLE  = 1'b0;
    localparam logic REQ_DISMISS = 1'b1;

    // Event kinds and pattern codes
    localparam logic [KIND_W-1:0] EVT_NONE  = 2'd0;
    localparam logic [KIND_W-1:0] EVT_BRAKE = 2'd1;
    localparam logic [KIND_W-1:0] EVT_CRASH = 2'd2;
    localparam logic [KIND_W-1:0] PAT_NONE  = 2'd0;
    localparam logic [KIND_W-1:0] PAT_BRAKE = 2'd1;
    localparam logic [KIND_W-1:0] PAT_CRASH = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CRASH_MAG_LIMIT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CRASH_JERK_LIMIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BRAKE_JERK_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BRAKE_MAG_CEILING = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BRAKE_COOLDOWN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CRASH_COOLDOWN    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BRAKE_HOLD        = 3'd6;

    // Configuration reset values
    localparam logic [MAG_W-1:0]  RST_CRASH_MAG_LIMIT   = 16'd12288;
    localparam logic [JERK_W-1:0] RST_CRASH_JERK_LIMIT  = 22'd163840;
    localparam logic [JERK_W-1:0] RST_BRAKE_JERK_LIMIT  = 22'd57344;
    localparam logic [MAG_W-1:0]  RST_BRAKE_MAG_CEILING = 16'd9011;
    localparam logic [15:0]       RST_BRAKE_COOLDOWN    = 16'd400;
    localparam logic [15:0]       RST_CRASH_COOLDOWN    = 16'd3000;
    localparam logic [15:0]       RST_BRAKE_HOLD        = 16'd800;

    // Magnitude before the first sample: one g
    localparam logic [MAG_W-1:0] ONE_G = 16'd4096;

    localparam logic [JERK_W-1:0] JERK_MAX = 22'h3FFFFF;

    // Confidence ramps: floor 51, span 204
    localparam logic [CONF_W-1:0] CONF_FLOOR = 8'd51;
    localparam logic [CONF_W-1:0] CONF_TOP   = 8'd255;
    // Brake ramp over 14..30 g/s, span 65536
    localparam logic [JERK_W-1:0] BRAKE_CONF_LO = 22'd57344;
    localparam logic [JERK_W-1:0] BRAKE_CONF_HI = 22'd122880;
    // Crash jerk ramp over 40..90 g/s, span 204800 = 4096 * 50
    localparam logic [JERK_W-1:0] CRASH_JERK_CONF_LO = 22'd163840;
    localparam logic [JERK_W-1:0] CRASH_JERK_CONF_HI = 22'd368640;
    // Crash magnitude ramp over 3..5 g, span 8192
    localparam logic [MAG_W-1:0] CRASH_MAG_CONF_LO = 16'd12288;
    localparam logic [MAG_W-1:0] CRASH_MAG_CONF_HI = 16'd20480;
    // Reciprocal of 50 at 2^19, exact for dividends below 10240
    localparam logic [26:0] RECIP_50   = 27'd10486;
    localparam int          RECIP_SHIFT = 19;

    // Square root: sixteen digit steps over a 32-bit radicand
    localparam logic [SUMSQ_W-1:0] SQRT_FIRST_BIT = 32'h4000_0000;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // One item as it travels from the front to the back
    typedef struct packed {
        logic                dismiss;
        logic [SUMSQ_W-1:0]  sumsq;
        logic [TIME_W-1:0]   now_ms;
    } queue_item_t;

    // Configuration register file contents
    typedef struct packed {
        logic [MAG_W-1:0]  crash_mag_limit;
        logic [JERK_W-1:0] crash_jerk_limit;
        logic [JERK_W-1:0] brake_jerk_limit;
        logic [MAG_W-1:0]  brake_mag_ceiling;
        logic [15:0]       brake_cooldown_ms;
        logic [15:0]       crash_cooldown_ms;
        logic [15:0]       brake_hold_ms;
    } cfg_regs_t;

endpackage

@@ rtl/core/ibed_front.sv @@
// Front end: takes input beats, squares the axes and sums them.
// Depends on ibed_pkg; feeds ibed_queue.
module ibed_front
    import ibed_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     req_type,
    input  logic signed [AXIS_W-1:0] accel_x,
    input  logic signed [AXIS_W-1:0] accel_y,
    input  logic signed [AXIS_W-1:0] accel_z,
    input  logic [TIME_W-1:0]        now_ms,
    output logic                     push_valid,
    input  logic                     push_ready,
    output queue_item_t              push_item
);

    localparam logic [1:0] F_IDLE   = 2'd0;
    localparam logic [1:0] F_SQUARE = 2'd1;
    localparam logic [1:0] F_PUSH   = 2'd2;

    logic [1:0] state_reg, state_next;

    logic                     dismiss_reg;
    logic [TIME_W-1:0]        now_reg;
    logic signed [AXIS_W-1:0] x_reg, y_reg, z_reg;
    logic [SUMSQ_W-1:0]       sqx_reg, sqy_reg, sqz_reg;

    logic signed [2*AXIS_W-1:0] sqx, sqy, sqz;

    assign in_ready   = (state_reg == F_IDLE);
    assign push_valid = (state_reg == F_PUSH);

    // Squares of signed axes are never negative
    assign sqx = x_reg * x_reg;
    assign sqy = y_reg * y_reg;
    assign sqz = z_reg * z_reg;

    // Sum the squares; a dismiss carries no radicand
    always_comb
    begin
        push_item.dismiss = dismiss_reg;
        push_item.now_ms  = now_reg;
        push_item.sumsq   = dismiss_reg ? '0 : (sqx_reg + sqy_reg + sqz_reg);
    end

    // Advance through capture, square and push
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (req_type == REQ_DISMISS) ? F_PUSH : F_SQUARE;
                end
            end
            F_SQUARE:
            begin
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Hold the accepted beat and its squares
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            dismiss_reg <= (req_type == REQ_DISMISS);
            now_reg     <= now_ms;
            x_reg       <= accel_x;
            y_reg       <= accel_y;
            z_reg       <= accel_z;
        end
        if (state_reg == F_SQUARE)
        begin
            sqx_reg <= SUMSQ_W'(unsigned'(sqx));
            sqy_reg <= SUMSQ_W'(unsigned'(sqy));
            sqz_reg <= SUMSQ_W'(unsigned'(sqz));
        end
    end

endmodule

@@ rtl/core/ibed_queue.sv @@
// Short queue that decouples the front end from the detector back end.
// Depends on ibed_pkg for the item type and depth.
module ibed_queue
    import ibed_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push_valid,
    output logic        push_ready,
    input  queue_item_t push_item,
    output logic        pop_valid,
    input  logic        pop_ready,
    output queue_item_t pop_item
);

    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

    queue_item_t           slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [COUNT_W-1:0]    count_reg;

    logic do_push, do_pop;

    assign push_ready = (count_reg != COUNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];

    assign do_push = push_valid && push_ready;
    assign do_pop  = pop_valid && pop_ready;

    // Advance pointers and track fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + COUNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - COUNT_W'(1);
            end
        end
    end

    // Store the pushed beat
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ rtl/core/ibed_back.sv @@
// Back end: iterative square root, jerk, confidence ramps and event decision.
// Depends on ibed_pkg; drains ibed_queue and drives the result registers.
module ibed_back
    import ibed_pkg::*;
#(
    parameter int SAMPLE_RATE = 50
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_regs_t          cfg,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  queue_item_t        pop_item,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [KIND_W-1:0]  event_kind,
    output logic [CONF_W-1:0]  confidence,
    output logic [KIND_W-1:0]  pattern,
    output logic [MAG_W-1:0]   magnitude,
    output logic [JERK_W-1:0]  jerk
);

    localparam int RATE_W = $clog2(SAMPLE_RATE + 1);
    localparam int PROD_W = MAG_W + RATE_W;
    localparam int EXT_W  = PROD_W + JERK_W;

    localparam logic [2:0] B_IDLE   = 3'd0;
    localparam logic [2:0] B_SQRT   = 3'd1;
    localparam logic [2:0] B_JERK   = 3'd2;
    localparam logic [2:0] B_RAMP_A = 3'd3;
    localparam logic [2:0] B_RAMP_B = 3'd4;
    localparam logic [2:0] B_DECIDE = 3'd5;

    logic [2:0] state_reg, state_next;

    // Item under work
    logic                dismiss_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [SUMSQ_W-1:0]  rem_reg, root_reg, bit_reg;
    logic [JERK_W-1:0]   jerk_reg;
    logic [CONF_W-1:0]   conf_brake_reg, conf_mag_reg, conf_crash_reg;
    logic [13:0]         cj_scaled_reg;
    logic                cj_low_reg, cj_high_reg;

    // Detector state
    logic [MAG_W-1:0]    prev_mag_reg, prev_mag_next;
    logic [TIME_W-1:0]   last_brake_reg, last_brake_next;
    logic [TIME_W-1:0]   last_crash_reg, last_crash_next;
    logic [TIME_W-1:0]   brake_end_reg, brake_end_next;
    logic [KIND_W-1:0]   pattern_reg, pattern_next;

    // Result registers
    logic                out_valid_reg;
    logic [KIND_W-1:0]   kind_out_reg, kind_next;
    logic [CONF_W-1:0]   conf_out_reg, conf_next;
    logic [KIND_W-1:0]   pat_out_reg;
    logic [MAG_W-1:0]    mag_out_reg;
    logic [JERK_W-1:0]   jerk_out_reg;

    logic [MAG_W-1:0]    mag;
    logic [SUMSQ_W-1:0]  trial;
    logic                fire;

    logic [MAG_W-1:0]    diff;
    logic [PROD_W-1:0]   jerk_prod;
    logic [EXT_W-1:0]    jerk_ext;
    logic [JERK_W-1:0]   jerk_sat;

    logic [JERK_W-1:0]   bj_d, cj_d;
    logic [MAG_W-1:0]    cm_d;
    logic [23:0]         bj_prod, cj_prod;
    logic [20:0]         cm_prod;
    logic [26:0]         cj_q_prod;
    logic [CONF_W-1:0]   conf_jerk;

    logic [TIME_W-1:0]   since_crash, since_brake, past_end;
    logic                crash_hit, brake_hit;

    assign mag       = root_reg[MAG_W-1:0];
    assign trial     = root_reg + bit_reg;
    assign pop_ready = (state_reg == B_IDLE);
    assign fire      = (state_reg == B_DECIDE) && (!out_valid_reg || out_ready);

    assign out_valid  = out_valid_reg;
    assign event_kind = kind_out_reg;
    assign confidence = conf_out_reg;
    assign pattern    = pat_out_reg;
    assign magnitude  = mag_out_reg;
    assign jerk       = jerk_out_reg;

    // Jerk: magnitude change times sample rate, saturated
    always_comb
    begin
        diff      = (mag > prev_mag_reg) ? (mag - prev_mag_reg) : (prev_mag_reg - mag);
        jerk_prod = PROD_W'(diff) * PROD_W'(SAMPLE_RATE);
        jerk_ext  = EXT_W'(jerk_prod);
        jerk_sat  = (jerk_ext > EXT_W'(JERK_MAX)) ? JERK_MAX : jerk_ext[JERK_W-1:0];
    end

    // Ramp numerators, scaled by the constant span of each ramp
    always_comb
    begin
        bj_d      = jerk_reg - BRAKE_CONF_LO;
        cj_d      = jerk_reg - CRASH_JERK_CONF_LO;
        cm_d      = mag - CRASH_MAG_CONF_LO;
        bj_prod   = 24'(bj_d[15:0]) * 24'd204;
        cj_prod   = 24'(cj_d[17:0]) * 24'd51;
        cm_prod   = 21'(cm_d[12:0]) * 21'd204;
        cj_q_prod = 27'(cj_scaled_reg) * RECIP_50;
    end

    // Finish the divide by 50 on the crash jerk ramp
    always_comb
    begin
        if (cj_low_reg)
        begin
            conf_jerk = CONF_FLOOR;
        end
        else if (cj_high_reg)
        begin
            conf_jerk = CONF_TOP;
        end
        else
        begin
            conf_jerk = CONF_FLOOR + cj_q_prod[RECIP_SHIFT+7:RECIP_SHIFT];
        end
    end

    // Decide the event and the next detector state
    always_comb
    begin
        since_crash     = now_reg - last_crash_reg;
        since_brake     = now_reg - last_brake_reg;
        past_end        = now_reg - brake_end_reg;
        prev_mag_next   = prev_mag_reg;
        last_brake_next = last_brake_reg;
        last_crash_next = last_crash_reg;
        brake_end_next  = brake_end_reg;
        pattern_next    = pattern_reg;
        kind_next       = EVT_NONE;
        conf_next       = '0;
        crash_hit       = 1'b0;
        brake_hit       = 1'b0;
        if (dismiss_reg)
        begin
            pattern_next = PAT_NONE;
        end
        else
        begin
            // Drop an expired brake pattern
            if (pattern_reg == PAT_BRAKE && past_end != '0 && !past_end[TIME_W-1])
            begin
                pattern_next = PAT_NONE;
            end
            crash_hit = (pattern_next != PAT_CRASH) &&
                        (since_crash >= TIME_W'(cfg.crash_cooldown_ms)) &&
                        ((mag > cfg.crash_mag_limit) || (jerk_reg > cfg.crash_jerk_limit));
            brake_hit = (since_brake >= TIME_W'(cfg.brake_cooldown_ms)) &&
                        (jerk_reg > cfg.brake_jerk_limit) &&
                        (mag < cfg.brake_mag_ceiling);
            if (crash_hit)
            begin
                last_crash_next = now_reg;
                pattern_next    = PAT_CRASH;
                kind_next       = EVT_CRASH;
                conf_next       = conf_crash_reg;
            end
            else if (brake_hit)
            begin
                last_brake_next = now_reg;
                brake_end_next  = now_reg + TIME_W'(cfg.brake_hold_ms);
                // A repeat brake only extends the hold
                if (pattern_next != PAT_BRAKE)
                begin
                    pattern_next = PAT_BRAKE;
                    kind_next    = EVT_BRAKE;
                    conf_next    = conf_brake_reg;
                end
            end
            prev_mag_next = mag;
        end
    end

    // Sequence one item through the back end
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = pop_item.dismiss ? B_DECIDE : B_SQRT;
                end
            end
            B_SQRT:
            begin
                if (bit_reg[0])
                begin
                    state_next = B_JERK;
                end
            end
            B_JERK:
            begin
                state_next = B_RAMP_A;
            end
            B_RAMP_A:
            begin
                state_next = B_RAMP_B;
            end
            B_RAMP_B:
            begin
                state_next = B_DECIDE;
            end
            B_DECIDE:
            begin
                if (fire)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Control and detector state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            out_valid_reg  <= 1'b0;
            prev_mag_reg   <= ONE_G;
            last_brake_reg <= '0;
            last_crash_reg <= '0;
            brake_end_reg  <= '0;
            pattern_reg    <= PAT_NONE;
        end
        else
        begin
            state_reg <= state_next;
            if (fire)
            begin
                out_valid_reg  <= 1'b1;
                prev_mag_reg   <= prev_mag_next;
                last_brake_reg <= last_brake_next;
                last_crash_reg <= last_crash_next;
                brake_end_reg  <= brake_end_next;
                pattern_reg    <= pattern_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath: root digits, jerk, ramps and the result beat
    always_ff @(posedge clk)
    begin
        if (pop_valid && pop_ready)
        begin
            dismiss_reg <= pop_item.dismiss;
            now_reg     <= pop_item.now_ms;
            rem_reg     <= pop_item.sumsq;
            root_reg    <= '0;
            bit_reg     <= SQRT_FIRST_BIT;
        end
        if (state_reg == B_SQRT)
        begin
            // One root digit per cycle
            if (rem_reg >= trial)
            begin
                rem_reg  <= rem_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (state_reg == B_JERK)
        begin
            jerk_reg <= jerk_sat;
        end
        if (state_reg == B_RAMP_A)
        begin
            if (jerk_reg <= BRAKE_CONF_LO)
            begin
                conf_brake_reg <= CONF_FLOOR;
            end
            else if (jerk_reg >= BRAKE_CONF_HI)
            begin
                conf_brake_reg <= CONF_TOP;
            end
            else
            begin
                conf_brake_reg <= CONF_FLOOR + bj_prod[23:16];
            end
            if (mag <= CRASH_MAG_CONF_LO)
            begin
                conf_mag_reg <= CONF_FLOOR;
            end
            else if (mag >= CRASH_MAG_CONF_HI)
            begin
                conf_mag_reg <= CONF_TOP;
            end
            else
            begin
                conf_mag_reg <= CONF_FLOOR + cm_prod[20:13];
            end
            cj_scaled_reg <= cj_prod[23:10];
            cj_low_reg    <= (jerk_reg <= CRASH_JERK_CONF_LO);
            cj_high_reg   <= (jerk_reg >= CRASH_JERK_CONF_HI);
        end
        if (state_reg == B_RAMP_B)
        begin
            // Take the larger crash ramp
            conf_crash_reg <= (conf_jerk > conf_mag_reg) ? conf_jerk : conf_mag_reg;
        end
        if (fire)
        begin
            kind_out_reg <= kind_next;
            conf_out_reg <= conf_next;
            pat_out_reg  <= pattern_next;
            mag_out_reg  <= dismiss_reg ? '0 : mag;
            jerk_out_reg <= dismiss_reg ? '0 : jerk_reg;
        end
    end

endmodule

@@ rtl/core/impact_brake_event_detector.sv @@
// Top level of the impact and brake event detector: configuration registers
// and the front end, queue and back end. Depends on ibed_pkg and all rtl/core modules.
//
// Each beat is either an accelerometer sample or a dismiss command and gives
// exactly one result beat, in order. The front end steps a sample through
// capture, square and push and a dismiss through capture and push, and hands
// it through a two-entry queue to the back end, so new beats are taken while
// the back end is busy or its result waits, as long as the queue has room.
// The back end takes a sample from the queue, then runs the digit-by-digit
// square root of x*x + y*y + z*z, the jerk, the ramp states B_RAMP_A and
// B_RAMP_B and the decide state, which waits for a free result register and
// loads it; a dismiss goes straight to decide. It takes no new item until the
// result is loaded; the square-root iteration sets the sustained sample rate.
// Configuration writes are always taken (cfg_ready stays high) and must only
// be made while the block is idle; indexes past the last register are ignored.
module impact_brake_event_detector
    import ibed_pkg::*;
#(
    parameter int SAMPLE_RATE = 50
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     req_type,
    input  logic signed [AXIS_W-1:0] accel_x,
    input  logic signed [AXIS_W-1:0] accel_y,
    input  logic signed [AXIS_W-1:0] accel_z,
    input  logic [TIME_W-1:0]        now_ms,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [KIND_W-1:0]        event_kind,
    output logic [CONF_W-1:0]        confidence,
    output logic [KIND_W-1:0]        pattern,
    output logic [MAG_W-1:0]         magnitude,
    output logic [JERK_W-1:0]        jerk
);

    cfg_regs_t   cfg_reg;
    logic        push_valid, push_ready, pop_valid, pop_ready;
    queue_item_t push_item, pop_item;

    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.crash_mag_limit   <= RST_CRASH_MAG_LIMIT;
            cfg_reg.crash_jerk_limit  <= RST_CRASH_JERK_LIMIT;
            cfg_reg.brake_jerk_limit  <= RST_BRAKE_JERK_LIMIT;
            cfg_reg.brake_mag_ceiling <= RST_BRAKE_MAG_CEILING;
            cfg_reg.brake_cooldown_ms <= RST_BRAKE_COOLDOWN;
            cfg_reg.crash_cooldown_ms <= RST_CRASH_COOLDOWN;
            cfg_reg.brake_hold_ms     <= RST_BRAKE_HOLD;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CRASH_MAG_LIMIT:   cfg_reg.crash_mag_limit   <= cfg_data[15:0];
                REG_CRASH_JERK_LIMIT:  cfg_reg.crash_jerk_limit  <= cfg_data[JERK_W-1:0];
                REG_BRAKE_JERK_LIMIT:  cfg_reg.brake_jerk_limit  <= cfg_data[JERK_W-1:0];
                REG_BRAKE_MAG_CEILING: cfg_reg.brake_mag_ceiling <= cfg_data[15:0];
                REG_BRAKE_COOLDOWN:    cfg_reg.brake_cooldown_ms <= cfg_data[15:0];
                REG_CRASH_COOLDOWN:    cfg_reg.crash_cooldown_ms <= cfg_data[15:0];
                REG_BRAKE_HOLD:        cfg_reg.brake_hold_ms     <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    ibed_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .accel_x    (accel_x),
        .accel_y    (accel_y),
        .accel_z    (accel_z),
        .now_ms     (now_ms),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    ibed_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    ibed_back #(
        .SAMPLE_RATE (SAMPLE_RATE)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_kind (event_kind),
        .confidence (confidence),
        .pattern    (pattern),
        .magnitude  (magnitude),
        .jerk       (jerk)
    );

endmodule
